>>> src/sequence_composition_classifier_macros.svh
// assertion macros shared by the classifier modules
// expects clk and rst_n in the scope of each use
`ifndef SEQUENCE_COMPOSITION_CLASSIFIER_MACROS_SVH
`define SEQUENCE_COMPOSITION_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
`define SCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCC_ASSERT_SAME(lbl, ante, cons, msg)
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/scc_pkg.sv
// types, constants and ratio helpers for the sequence composition classifier
// no dependencies
`default_nettype none

package scc_pkg;

  localparam int unsigned MAX_BYTES = 1024;
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int unsigned TXT_W     = $clog2(3 * MAX_BYTES + 1);
  localparam int unsigned PROD_W    = TXT_W + 8;

  localparam logic [1:0] KIND_UNDEF = 2'd0;
  localparam logic [1:0] KIND_NUC   = 2'd1;
  localparam logic [1:0] KIND_PROT  = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_UG    = 8'h47;
  localparam logic [7:0] CH_UJ    = 8'h4A;
  localparam logic [7:0] CH_UN    = 8'h4E;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_UT    = 8'h54;
  localparam logic [7:0] CH_UU    = 8'h55;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // share thresholds as num/den pairs
  localparam logic [7:0] DEN_TENTHS   = 8'd10;
  localparam logic [7:0] NUM_KIND     = 8'd7;
  localparam logic [7:0] NUM_TEXT_LO  = 8'd8;
  localparam logic [7:0] DEN_HUNDRED  = 8'd100;
  localparam logic [7:0] NUM_TEXT_HI  = 8'd91;
  localparam logic [7:0] HALF_NUM     = 8'd2;
  localparam logic [7:0] UNIT         = 8'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_payload_t;

  typedef struct packed {
    logic       is_fasta;
    logic [1:0] sequence_kind;
    logic       too_long;
  } out_payload_t;

  typedef struct packed {
    logic eol;
    logic text;
    logic nuc;
    logic prot;
    logic gt;
  } byte_class_t;

  typedef struct packed {
    logic             overflow;
    logic             starts_hdr;
    logic             in_first_line;
    logic [CNT_W-1:0] byte_total;
    logic [CNT_W-1:0] first_line_length;
    logic [TXT_W-1:0] text_total;
    logic [CNT_W-1:0] nuc_total;
    logic [CNT_W-1:0] prot_total;
    logic [CNT_W-1:0] line_end_total;
    logic [CNT_W-1:0] body_nuc;
    logic [CNT_W-1:0] body_prot;
    logic [CNT_W-1:0] body_len;
    logic [CNT_W-1:0] hdr_nuc;
    logic [CNT_W-1:0] hdr_prot;
    logic [CNT_W-1:0] hdr_len;
  } tallies_t;

  typedef struct packed {
    logic item_go;
    logic snap_valid;
  } cnt_status_t;

  localparam tallies_t TALLIES_RESET = '{
    overflow: 1'b0, starts_hdr: 1'b0, in_first_line: 1'b1,
    byte_total: '0, first_line_length: '0, text_total: '0,
    nuc_total: '0, prot_total: '0, line_end_total: '0,
    body_nuc: '0, body_prot: '0, body_len: '0,
    hdr_nuc: '0, hdr_prot: '0, hdr_len: '0
  };

  function automatic logic [PROD_W-1:0] scale(input logic [TXT_W-1:0] x,
                                               input logic [7:0] k);
    return PROD_W'(x) * PROD_W'(k);
  endfunction

  // share a/b above 0.7; an empty divisor counts as above when a is nonzero
  function automatic logic share_above_kind(input logic [CNT_W-1:0] a,
                                            input logic [CNT_W-1:0] b);
    if (b == '0) begin
      return a != '0;
    end
    return scale(TXT_W'(a), DEN_TENTHS) > scale(TXT_W'(b), NUM_KIND);
  endfunction

endpackage

`default_nettype wire

>>> src/sequence_composition_classifier.sv
// top level: input register, tally stage with snapshot, verdict and result register
// depends on scc_pkg, scc_decode, scc_count, scc_verdict and the macro header
//
//   channel  | ports                          | payload
//   ---------+--------------------------------+--------------------------------
//   input    | in_valid, in_ready, in_data    | data_byte, last_byte
//   result   | out_valid, out_ready, out_data | is_fasta, sequence_kind, too_long
//
// one byte per cycle unless stalled; the snapshot feeds the result register
// the rate is set by the tally counters, each updated once per byte
// the input register, the snapshot and the result register each hold one item,
// so bytes keep flowing while a result waits; only a second pending last byte stalls
// rst_n is synchronous, active low, and clears the live tallies and all valid flags
`default_nettype none
`include "sequence_composition_classifier_macros.svh"

module sequence_composition_classifier (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire scc_pkg::in_payload_t  in_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output scc_pkg::out_payload_t      out_data
);

  scc_pkg::in_payload_t  item_r, item_nxt;
  logic                  item_valid_r, item_valid_nxt;
  scc_pkg::byte_class_t  cls;
  scc_pkg::cnt_status_t  status;
  scc_pkg::tallies_t     snap;
  scc_pkg::out_payload_t verdict;
  scc_pkg::out_payload_t out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  snap_pop;

  assign snap_pop = status.snap_valid && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || status.item_go;

  scc_decode u_decode (
    .data_byte (item_r.data_byte),
    .cls       (cls)
  );

  scc_count u_count (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid_r),
    .item_last  (item_r.last_byte),
    .cls        (cls),
    .snap_pop   (snap_pop),
    .status     (status),
    .snap       (snap)
  );

  scc_verdict u_verdict (
    .t   (snap),
    .res (verdict)
  );

  always_comb begin
    item_nxt       = item_r;
    item_valid_nxt = item_valid_r && !status.item_go;
    if (in_valid && in_ready) begin
      item_nxt       = in_data;
      item_valid_nxt = 1'b1;
    end
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (snap_pop) begin
      out_nxt       = verdict;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SCC_ASSERT_SAME(a_too_long_clean, out_valid_r && out_r.too_long,
    !out_r.is_fasta && out_r.sequence_kind == scc_pkg::KIND_UNDEF,
    "too long result carries verdict")
  `SCC_ASSERT_NEXT(a_result_from_snap, snap_pop,
    out_valid_r && out_r == $past(verdict),
    "result register missed a snapshot")

endmodule

`default_nettype wire

>>> src/scc_decode.sv
// byte classifier: line end, text, nucleotide, protein and header marker flags
// depends on scc_pkg
`default_nettype none

module scc_decode (
  input  wire logic [7:0]          data_byte,
  output scc_pkg::byte_class_t     cls
);

  logic [7:0] up;

  always_comb begin
    up = (data_byte >= scc_pkg::CH_LA && data_byte <= scc_pkg::CH_LZ) ?
         data_byte - scc_pkg::CASE_GAP : data_byte;
    cls.eol  = (data_byte == scc_pkg::CH_CR) || (data_byte == scc_pkg::CH_LF);
    cls.text = (data_byte >= scc_pkg::CH_ZERO && data_byte <= scc_pkg::CH_NINE) ||
               (data_byte >= scc_pkg::CH_UA && data_byte <= scc_pkg::CH_UZ) ||
               (data_byte >= scc_pkg::CH_LA && data_byte <= scc_pkg::CH_LZ) ||
               (data_byte >= scc_pkg::CH_TAB && data_byte <= scc_pkg::CH_CR) ||
               (data_byte == scc_pkg::CH_SPACE);
    cls.nuc  = (up == scc_pkg::CH_UA) || (up == scc_pkg::CH_UT) ||
               (up == scc_pkg::CH_UG) || (up == scc_pkg::CH_UC) ||
               (up == scc_pkg::CH_UN);
    cls.prot = (up >= scc_pkg::CH_UA) && (up <= scc_pkg::CH_UZ) &&
               (up != scc_pkg::CH_UJ) && (up != scc_pkg::CH_UO) &&
               (up != scc_pkg::CH_UU);
    cls.gt   = (data_byte == scc_pkg::CH_GT);
  end

endmodule

`default_nettype wire

>>> src/scc_count.sv
// running tallies for one buffer and the snapshot taken at its last byte
// depends on scc_pkg and the assertion macro header
`default_nettype none
`include "sequence_composition_classifier_macros.svh"

module scc_count (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid,
  input  wire logic                 item_last,
  input  wire scc_pkg::byte_class_t cls,
  input  wire logic                 snap_pop,
  output scc_pkg::cnt_status_t      status,
  output scc_pkg::tallies_t         snap
);

  scc_pkg::tallies_t live_r, live_nxt, upd;
  scc_pkg::tallies_t snap_r, snap_nxt;
  logic              at_line_start_r, at_line_start_nxt, at_line_start_upd;
  logic              line_is_header_r, line_is_header_nxt, line_is_header_upd;
  logic              snap_valid_r, snap_valid_nxt;
  logic              item_go;
  logic              hdr_line;
  logic              starts_hdr;

  assign item_go = item_valid && (!item_last || !snap_valid_r || snap_pop);

  // effect of one byte on the tallies
  always_comb begin
    upd                = live_r;
    at_line_start_upd  = at_line_start_r;
    line_is_header_upd = line_is_header_r;
    starts_hdr         = (live_r.byte_total == '0) ? cls.gt : live_r.starts_hdr;
    hdr_line           = at_line_start_r ? cls.gt : line_is_header_r;
    if (!live_r.overflow) begin
      if (live_r.byte_total >= scc_pkg::CNT_W'(scc_pkg::MAX_BYTES)) begin
        upd.overflow = 1'b1;
      end else begin
        upd.starts_hdr = starts_hdr;
        upd.byte_total = live_r.byte_total + scc_pkg::CNT_W'(1);
        upd.nuc_total  = live_r.nuc_total + scc_pkg::CNT_W'(cls.nuc);
        upd.prot_total = live_r.prot_total + scc_pkg::CNT_W'(cls.prot);
        if (cls.eol) begin
          upd.text_total     = live_r.text_total + scc_pkg::TXT_W'(cls.text)
                               + scc_pkg::TXT_W'(1);
          upd.line_end_total = live_r.line_end_total + scc_pkg::CNT_W'(1);
          upd.in_first_line  = 1'b0;
          at_line_start_upd  = 1'b1;
        end else begin
          upd.text_total = live_r.text_total + scc_pkg::TXT_W'(cls.text)
                           + scc_pkg::TXT_W'(live_r.in_first_line && starts_hdr
                                             && cls.text);
          if (live_r.in_first_line) begin
            upd.first_line_length = live_r.first_line_length + scc_pkg::CNT_W'(1);
          end
          at_line_start_upd  = 1'b0;
          line_is_header_upd = hdr_line;
          if (hdr_line) begin
            upd.hdr_len  = live_r.hdr_len + scc_pkg::CNT_W'(1);
            upd.hdr_nuc  = live_r.hdr_nuc + scc_pkg::CNT_W'(cls.nuc);
            upd.hdr_prot = live_r.hdr_prot + scc_pkg::CNT_W'(cls.prot);
          end else begin
            upd.body_len  = live_r.body_len + scc_pkg::CNT_W'(1);
            upd.body_nuc  = live_r.body_nuc + scc_pkg::CNT_W'(cls.nuc);
            upd.body_prot = live_r.body_prot + scc_pkg::CNT_W'(cls.prot);
          end
        end
      end
    end
  end

  always_comb begin
    live_nxt           = live_r;
    at_line_start_nxt  = at_line_start_r;
    line_is_header_nxt = line_is_header_r;
    snap_nxt           = snap_r;
    snap_valid_nxt     = snap_valid_r && !snap_pop;
    if (item_go) begin
      if (item_last) begin
        live_nxt           = scc_pkg::TALLIES_RESET;
        at_line_start_nxt  = 1'b1;
        line_is_header_nxt = 1'b0;
        snap_nxt           = upd;
        snap_valid_nxt     = 1'b1;
      end else begin
        live_nxt           = upd;
        at_line_start_nxt  = at_line_start_upd;
        line_is_header_nxt = line_is_header_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r           <= scc_pkg::TALLIES_RESET;
      at_line_start_r  <= 1'b1;
      line_is_header_r <= 1'b0;
      snap_valid_r     <= 1'b0;
    end else begin
      live_r           <= live_nxt;
      at_line_start_r  <= at_line_start_nxt;
      line_is_header_r <= line_is_header_nxt;
      snap_valid_r     <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign status.item_go    = item_go;
  assign status.snap_valid = snap_valid_r;
  assign snap              = snap_r;

  `SCC_ASSERT_NEXT(a_clear_after_last, item_go && item_last,
    live_r.byte_total == '0 && !live_r.overflow && at_line_start_r,
    "tallies not cleared after last byte")
  `SCC_ASSERT_SAME(a_total_bound, 1'b1,
    live_r.byte_total <= scc_pkg::CNT_W'(scc_pkg::MAX_BYTES),
    "byte total beyond limit")
  `SCC_ASSERT_SAME(a_line_bound, 1'b1,
    scc_pkg::TXT_W'(live_r.first_line_length) + scc_pkg::TXT_W'(live_r.line_end_total)
    <= scc_pkg::TXT_W'(live_r.byte_total),
    "first line and line ends exceed byte total")
  `SCC_ASSERT_NEXT(a_snap_held, snap_valid_r && !snap_pop,
    snap_valid_r && snap_r == $past(snap_r),
    "pending snapshot lost or changed")

endmodule

`default_nettype wire

>>> src/scc_verdict.sv
// kind and two-hypothesis fasta verdict from a finished buffer's tallies
// depends on scc_pkg
`default_nettype none

module scc_verdict (
  input  wire scc_pkg::tallies_t  t,
  output scc_pkg::out_payload_t   res
);

  logic [scc_pkg::CNT_W-1:0] seq_len;
  logic                      text_hi, text_mid, hyp1, hyp2, nuc_ok, prot_ok;
  logic [1:0]                kind;

  always_comb begin
    seq_len  = t.byte_total - t.first_line_length - t.line_end_total;
    text_hi  = scc_pkg::scale(t.text_total, scc_pkg::DEN_HUNDRED) >
               scc_pkg::scale(scc_pkg::TXT_W'(t.byte_total), scc_pkg::NUM_TEXT_HI);
    text_mid = scc_pkg::scale(t.text_total, scc_pkg::DEN_TENTHS) >
               scc_pkg::scale(scc_pkg::TXT_W'(t.byte_total), scc_pkg::NUM_TEXT_LO);
    hyp1     = (scc_pkg::share_above_kind(t.nuc_total, seq_len) ||
                scc_pkg::share_above_kind(t.prot_total, seq_len)) && text_hi;
    nuc_ok   = scc_pkg::scale(scc_pkg::TXT_W'(t.body_nuc), scc_pkg::DEN_HUNDRED) >
               scc_pkg::scale(scc_pkg::TXT_W'(t.body_len), scc_pkg::NUM_TEXT_HI) &&
               scc_pkg::scale(scc_pkg::TXT_W'(t.hdr_nuc), scc_pkg::HALF_NUM) <
               scc_pkg::scale(scc_pkg::TXT_W'(t.hdr_len), scc_pkg::UNIT);
    prot_ok  = scc_pkg::scale(scc_pkg::TXT_W'(t.body_prot), scc_pkg::DEN_HUNDRED) >
               scc_pkg::scale(scc_pkg::TXT_W'(t.body_len), scc_pkg::NUM_TEXT_HI) &&
               scc_pkg::scale(scc_pkg::TXT_W'(t.hdr_prot), scc_pkg::HALF_NUM) <
               scc_pkg::scale(scc_pkg::TXT_W'(t.hdr_len), scc_pkg::UNIT);
    hyp2     = text_mid && (t.body_len != '0) && (t.hdr_len != '0) && (nuc_ok || prot_ok);
    if (scc_pkg::share_above_kind(t.nuc_total, t.byte_total)) begin
      kind = scc_pkg::KIND_NUC;
    end else if (scc_pkg::share_above_kind(t.prot_total, t.byte_total)) begin
      kind = scc_pkg::KIND_PROT;
    end else begin
      kind = scc_pkg::KIND_UNDEF;
    end
    if (t.overflow) begin
      res.is_fasta      = 1'b0;
      res.sequence_kind = scc_pkg::KIND_UNDEF;
      res.too_long      = 1'b1;
    end else begin
      res.is_fasta      = t.starts_hdr && !t.in_first_line && (hyp1 || hyp2);
      res.sequence_kind = kind;
      res.too_long      = 1'b0;
    end
  end

endmodule

`default_nettype wire
